// ===== rtl/iirl_pkg.sv =====
// ----------------------------------------------------------------------------
// iirl_pkg: shared types and constants for the indexed insert/remove list
// Sizes, request kinds, status codes and the command/result records.
// ----------------------------------------------------------------------------
package iirl_pkg;

  localparam int CAPACITY = 16;                       // entries in the list
  localparam int WORD_W   = 32;                       // entry width
  localparam int KIND_W   = 3;
  localparam int POSIN_W  = 5;                        // position port width
  localparam int LEN_W    = 5;                        // length port width
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);     // holds 0..CAPACITY
  localparam int POS_W    = $clog2(CAPACITY);         // cell index
  localparam int CMP_W    = (CNT_W > POSIN_W) ? CNT_W : POSIN_W;

  // Command queue and result queue sizes
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT       = 3'd0,
    KIND_APPEND       = 3'd1,
    KIND_REMOVE_LAST  = 3'd2,
    KIND_REMOVE_FIRST = 3'd3,
    KIND_READ         = 3'd4,
    KIND_CLEAR        = 3'd5,
    KIND_SPARE6       = 3'd6,   // unused, does nothing
    KIND_SPARE7       = 3'd7    // unused, does nothing
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Decoded operation, one-hot
  typedef enum logic [6:0] {
    OP_INSERT       = 7'b0000001,
    OP_APPEND       = 7'b0000010,
    OP_REMOVE_LAST  = 7'b0000100,
    OP_REMOVE_FIRST = 7'b0001000,
    OP_READ         = 7'b0010000,
    OP_CLEAR        = 7'b0100000,
    OP_NOP          = 7'b1000000
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [WORD_W-1:0]  value;
    logic [POSIN_W-1:0]        position;
  } cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  read_data;
    logic [LEN_W-1:0]          length;
    status_t                   status;
  } res_t;

endpackage

// ===== rtl/indexed_insert_remove_list_core.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_core: bounded ordered list of 32-bit words
// Insert-before, append, remove last/first, read and clear on a list of up
// to CAPACITY signed words, one result item per request item.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue write port: drive in_kind/in_value/in_position
//   and raise in_push; the item is taken on an edge where in_full is low.
//   Result side is a queue read port: while out_empty is low the oldest
//   result sits on out_read_data/out_length/out_status; raise out_pop to
//   take it. Results come back in request order, exactly one per request.
//   A request passes the two-entry command queue, then the execution stage.
//   Throughput: one request per cycle while the result queue has room. The
//   cell array shifts entries in parallel, so insert and remove-first cost
//   the same as a read. If out_pop stays low, the two-entry result queue
//   fills, the execution stage stops taking commands, the command queue
//   fills and in_full rises; nothing is dropped. Reset (rst_n low,
//   synchronous) empties the list and both queues; stored words are not
//   cleared and are never read unwritten.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [iirl_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [iirl_pkg::WORD_W-1:0]  in_value,
  input  logic [iirl_pkg::POSIN_W-1:0]        in_position,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [iirl_pkg::WORD_W-1:0]  out_read_data,
  output logic [iirl_pkg::LEN_W-1:0]          out_length,
  output logic [iirl_pkg::STAT_W-1:0]         out_status
);

  // Front/back link
  logic            cmd_valid;
  logic            cmd_take;
  iirl_pkg::cmd_t  cmd;
  iirl_pkg::res_t  res;

  iirl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_kind     (in_kind),
    .in_value    (in_value),
    .in_position (in_position),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  iirl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_read_data = res.read_data;
  assign out_length    = res.length;
  assign out_status    = res.status;

  // Full status only when the list really is at capacity
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == iirl_pkg::ST_FULL)
      |-> out_length == iirl_pkg::LEN_W'(iirl_pkg::CAPACITY))
    else $error("full status with short list");

  // Empty status only on an empty list
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == iirl_pkg::ST_EMPTY) |-> out_length == '0)
    else $error("empty status with entries present");

  // Read data is only nonzero for a successful read
  a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_read_data != '0) |-> out_status == iirl_pkg::ST_OK)
    else $error("read data on failed request");

  // Reset leaves both queues empty
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

// ===== rtl/iirl_front.sv =====
// ----------------------------------------------------------------------------
// iirl_front: request intake
// Accepts items, decodes the kind and holds them in a short command queue.
// ----------------------------------------------------------------------------
module iirl_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [iirl_pkg::KIND_W-1:0]       in_kind,
  input  logic signed [iirl_pkg::WORD_W-1:0] in_value,
  input  logic [iirl_pkg::POSIN_W-1:0]      in_position,
  output logic                              cmd_valid,
  output iirl_pkg::cmd_t                    cmd,
  input  logic                              cmd_take
);

  iirl_pkg::cmd_t                  q_r [iirl_pkg::QDEPTH];
  logic [iirl_pkg::QPTR_W-1:0]     wptr_r, wptr_nxt;
  logic [iirl_pkg::QPTR_W-1:0]     rptr_r, rptr_nxt;
  logic [iirl_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  iirl_pkg::op_t                   op_dec;
  logic                            push_ok;

  always_comb begin
    unique case (in_kind)
      iirl_pkg::KIND_INSERT:       op_dec = iirl_pkg::OP_INSERT;
      iirl_pkg::KIND_APPEND:       op_dec = iirl_pkg::OP_APPEND;
      iirl_pkg::KIND_REMOVE_LAST:  op_dec = iirl_pkg::OP_REMOVE_LAST;
      iirl_pkg::KIND_REMOVE_FIRST: op_dec = iirl_pkg::OP_REMOVE_FIRST;
      iirl_pkg::KIND_READ:         op_dec = iirl_pkg::OP_READ;
      iirl_pkg::KIND_CLEAR:        op_dec = iirl_pkg::OP_CLEAR;
      default:                     op_dec = iirl_pkg::OP_NOP;   // unused kinds
    endcase
  end

  assign in_full   = (cnt_r == iirl_pkg::QCNT_W'(iirl_pkg::QDEPTH));
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push_ok) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (cmd_take) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    if (push_ok && !cmd_take) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_ok && cmd_take) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wptr_r] <= '{op: op_dec, value: in_value, position: in_position};
    end
  end

endmodule

// ===== rtl/iirl_back.sv =====
// ----------------------------------------------------------------------------
// iirl_back: list execution
// Shifting cell array plus length counter; one command per cycle while the
// result queue has room; results go to a short result queue.
// ----------------------------------------------------------------------------
module iirl_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  input  iirl_pkg::cmd_t                     cmd,
  output logic                               cmd_take,
  output logic                               out_empty,
  input  logic                               out_pop,
  output iirl_pkg::res_t                     res
);

  logic signed [iirl_pkg::WORD_W-1:0] cells_r [iirl_pkg::CAPACITY];
  logic [iirl_pkg::CNT_W-1:0]         count_r, count_nxt;

  iirl_pkg::res_t                     rq_r [iirl_pkg::QDEPTH];
  logic [iirl_pkg::QPTR_W-1:0]        wptr_r, rptr_r;
  logic [iirl_pkg::QCNT_W-1:0]        ocnt_r, ocnt_nxt;

  logic [iirl_pkg::CMP_W-1:0]         cnt_ext, pos_ext;
  logic                               is_full;
  logic                               do_ins, do_popf;
  logic [iirl_pkg::CNT_W-1:0]         ins_idx;
  iirl_pkg::status_t                  st;
  logic signed [iirl_pkg::WORD_W-1:0] rd;
  logic                               pop_ok;

  assign pop_ok    = out_pop && !out_empty;
  assign out_empty = (ocnt_r == '0);
  assign res       = rq_r[rptr_r];
  assign cmd_take  = cmd_valid && (ocnt_r != iirl_pkg::QCNT_W'(iirl_pkg::QDEPTH));

  assign cnt_ext = iirl_pkg::CMP_W'(count_r);
  assign pos_ext = iirl_pkg::CMP_W'(cmd.position);
  assign is_full = (count_r == iirl_pkg::CNT_W'(iirl_pkg::CAPACITY));

  always_comb begin
    st        = iirl_pkg::ST_OK;
    rd        = '0;
    count_nxt = count_r;
    do_ins    = 1'b0;
    do_popf   = 1'b0;
    ins_idx   = (cmd.op == iirl_pkg::OP_APPEND) ? count_r
                                                : iirl_pkg::CNT_W'(cmd.position);
    unique case (cmd.op)
      iirl_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          st = iirl_pkg::ST_RANGE;           // range check wins over full
        end else if (is_full) begin
          st = iirl_pkg::ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      iirl_pkg::OP_APPEND: begin
        if (is_full) begin
          st = iirl_pkg::ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      iirl_pkg::OP_REMOVE_LAST: begin
        if (count_r == '0) begin
          st = iirl_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      iirl_pkg::OP_REMOVE_FIRST: begin
        if (count_r == '0) begin
          st = iirl_pkg::ST_EMPTY;
        end else begin
          do_popf   = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      iirl_pkg::OP_READ: begin
        if (pos_ext >= cnt_ext) begin
          st = iirl_pkg::ST_RANGE;
        end else begin
          rd = cells_r[cmd.position[iirl_pkg::POS_W-1:0]];
        end
      end
      iirl_pkg::OP_CLEAR: begin
        count_nxt = '0;                      // stored words stay as they are
      end
      default: begin
      end
    endcase
  end

  // Cell array: every cell picks hold, its lower neighbor, its upper
  // neighbor or the new word, so the whole array shifts in parallel.
  for (genvar i = 0; i < iirl_pkg::CAPACITY; i++) begin : g_cell
    localparam logic [iirl_pkg::CNT_W-1:0] IDX = iirl_pkg::CNT_W'(i);
    always_ff @(posedge clk) begin
      if (cmd_take && do_ins) begin
        if (IDX == ins_idx) begin
          cells_r[i] <= cmd.value;
        end else if (IDX > ins_idx) begin
          if (i > 0) begin
            cells_r[i] <= cells_r[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (cmd_take && do_popf) begin
        if (i < iirl_pkg::CAPACITY - 1) begin
          cells_r[i] <= cells_r[(i < iirl_pkg::CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (cmd_take && !pop_ok) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (!cmd_take && pop_ok) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wptr_r  <= '0;
      rptr_r  <= '0;
      ocnt_r  <= '0;
    end else begin
      if (cmd_take) begin
        count_r <= count_nxt;
        wptr_r  <= wptr_r + 1'b1;
      end
      if (pop_ok) begin
        rptr_r <= rptr_r + 1'b1;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      rq_r[wptr_r] <= '{read_data: rd,
                        length:    iirl_pkg::LEN_W'(count_nxt),
                        status:    st};
    end
  end

endmodule
